// ===== design/rrs_pkg.sv =====
// Shared types and constants for the round-robin scheduler.
// No dependencies; imported by every other design file.
package rrs_pkg;

    localparam int NUM_PROCS = 8;
    localparam int SLOT_BITS = 3;
    localparam int CNT_BITS  = 4;
    localparam int TIME_BITS = 16;
    localparam int Q_BITS    = 8;
    localparam logic [Q_BITS-1:0] QUANTUM_RESET = 8'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic REG_QUANTUM = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_RUN,
        ST_SCAN,
        ST_FIN
    } fsm_state_t;

    typedef enum logic [1:0] {
        PS_ABSENT,
        PS_READY,
        PS_BLOCKED,
        PS_FINISHED
    } proc_state_t;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_CONT,
        EV_FINISH,
        EV_BLOCK,
        EV_PREEMPT
    } run_event_t;

    // One entry of the blocked list: the slot and the time at which it wakes.
    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [TIME_BITS-1:0] wake;
    } blk_entry_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic ld;
        logic ins;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== design/rrs_blk_cell.sv =====
// One blocked-list cell: holds an entry; loads, inserts or takes its right neighbor's.
// Depends on rrs_pkg.
module rrs_blk_cell (
    input  logic               aclk,
    input  rrs_pkg::cell_ctrl_t ctrl,
    input  rrs_pkg::blk_entry_t ld_data,
    input  rrs_pkg::blk_entry_t ins_data,
    input  rrs_pkg::blk_entry_t right_data,
    output rrs_pkg::blk_entry_t entry
);
    import rrs_pkg::*;

    blk_entry_t entry_reg;
    blk_entry_t entry_next;

    always_comb begin
        if (ctrl.ld) begin
            entry_next = ld_data;
        end else if (ctrl.ins) begin
            entry_next = ins_data;
        end else if (ctrl.shift) begin
            entry_next = right_data;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== design/rrs_mod_unit.sv =====
// Serial remainder unit: one quotient bit per cycle, flags a zero remainder.
// Depends on rrs_pkg.
module rrs_mod_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rrs_pkg::TIME_BITS-1:0] dividend,
    input  logic [rrs_pkg::Q_BITS-1:0]    divisor,
    output logic                          done,
    output logic                          rem_zero
);
    import rrs_pkg::*;

    localparam int STEP_BITS = $clog2(TIME_BITS + 1);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(TIME_BITS);

    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [TIME_BITS-1:0] dv_reg, dv_next;
    logic [Q_BITS-1:0]    rem_reg, rem_next;
    logic [Q_BITS:0]      trial;

    always_comb begin
        trial     = {rem_reg, dv_reg[TIME_BITS-1]};
        step_next = step_reg;
        dv_next   = dv_reg;
        rem_next  = rem_reg;
        if (start) begin
            step_next = '0;
            dv_next   = dividend;
            rem_next  = '0;
        end else if (step_reg != LAST_STEP) begin
            step_next = step_reg + 1'b1;
            dv_next   = {dv_reg[TIME_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = Q_BITS'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[Q_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= LAST_STEP;
        end else begin
            step_reg <= step_next;
        end
        dv_reg  <= dv_next;
        rem_reg <= rem_next;
    end

    assign done     = (step_reg == LAST_STEP);
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== design/round_robin_scheduler_with_blocking_core.sv =====
// Top level of the round-robin process scheduler with blocking.
// Depends on rrs_pkg, rrs_mod_unit and rrs_blk_cell.
//
// Usage: each input request on the s_ channel is either a load (s_tuser = 0)
// that writes a process descriptor into a slot and queues it, or a tick
// (s_tuser = 1) that advances the global time, runs the head of the ready
// queue for one unit and wakes every blocked process whose wait ends now.
// Every request yields exactly one result request on the m_ channel.
// The user must write the quantum register over the APB port only while the
// block is idle; the block itself does not enforce this.
// Order of work: a load goes from acceptance straight to the final step,
// which registers the result. A tick first forms the serial remainder of
// the time by the quantum, one quotient step per time bit, until the unit
// reports done; then it runs the run step; then, if entries are blocked
// after the run step, it scans them one at a time as the blocked list shifts
// through its chain of cells; last, it registers the result. One request is
// in work at a time; the next one is taken in the cycle after the result is
// registered.
//
// Reset clears the time, the queues and every slot to absent; the quantum
// returns to 2. When the receiver stalls, the finished result waits in the
// output register, a new request is still taken, and its result waits in the
// last step until the output register is free.
module round_robin_scheduler_with_blocking_core (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: proc_id[2:0], need_time[18:3], used_time[34:19],
    //          block_at[51:35], block_len[67:52], zero fill [71:68]
    input  logic [71:0] s_tdata,
    // s_tuser: mode
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: now[15:0], ran_valid[16], ran_id[19:17], run_event[22:20],
    //          woken_mask[30:23], all_done[31]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rrs_pkg::*;

    // Input fields.
    logic [SLOT_BITS-1:0] in_proc_id;
    logic [TIME_BITS-1:0] in_need, in_used, in_len;
    logic [TIME_BITS:0]   in_block_at;

    assign in_proc_id  = s_tdata[2:0];
    assign in_need     = s_tdata[18:3];
    assign in_used     = s_tdata[34:19];
    assign in_block_at = s_tdata[51:35];
    assign in_len      = s_tdata[67:52];

    // Control and state.
    fsm_state_t state_reg, state_next;
    logic [TIME_BITS-1:0] tick_count_reg;
    logic [Q_BITS-1:0]    quantum_reg;

    logic [TIME_BITS-1:0] remaining_reg [NUM_PROCS];
    logic [TIME_BITS-1:0] consumed_reg [NUM_PROCS];
    logic [TIME_BITS:0]   block_point_reg [NUM_PROCS];
    logic [TIME_BITS-1:0] block_length_reg [NUM_PROCS];
    proc_state_t          status_reg [NUM_PROCS];
    logic [SLOT_BITS-1:0] fifo_reg [NUM_PROCS];

    logic [SLOT_BITS-1:0] head_reg;
    logic [CNT_BITS-1:0]  rcount_reg;
    logic [CNT_BITS-1:0]  bcount_reg;
    logic [CNT_BITS-1:0]  scan_idx_reg;
    logic [CNT_BITS-1:0]  kept_reg;

    logic                 ran_valid_reg;
    logic [SLOT_BITS-1:0] ran_id_reg;
    run_event_t           event_reg;
    logic [NUM_PROCS-1:0] woken_reg;
    logic [31:0]          out_data_reg;
    logic                 m_tvalid_reg;

    // Handshake decode.
    logic in_accept, cfg_write, is_tick;
    logic out_free;

    assign in_accept = s_tvalid && s_tready;
    assign is_tick   = (s_tuser == MODE_TICK);
    assign cfg_write = psel && penable && pwrite && pready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Run-step datapath: the head slot of the ready queue.
    logic [SLOT_BITS-1:0] head_slot, tail_pos;
    logic [TIME_BITS-1:0] rem_dec, cons_inc, tick_inc;
    logic                 run_any, run_fin, run_blk, run_pre, blk_now;
    logic                 mod_done, mod_zero;
    logic                 load_ok;

    assign head_slot = fifo_reg[head_reg];
    assign tail_pos  = head_reg + rcount_reg[SLOT_BITS-1:0];
    assign tick_inc  = tick_count_reg + 1'b1;
    assign rem_dec   = (remaining_reg[head_slot] == '0) ? '0
                                                        : remaining_reg[head_slot] - 1'b1;
    assign cons_inc  = consumed_reg[head_slot] + 1'b1;
    assign run_any   = (rcount_reg != '0);
    assign run_fin   = (rem_dec == '0);
    assign run_blk   = !block_point_reg[head_slot][TIME_BITS]
                       && (block_point_reg[head_slot][TIME_BITS-1:0] == cons_inc);
    assign run_pre   = (quantum_reg != '0) && (tick_count_reg != '0) && mod_zero;
    assign blk_now   = run_any && !run_fin && run_blk;
    assign load_ok   = (status_reg[in_proc_id] != PS_READY)
                       && (status_reg[in_proc_id] != PS_BLOCKED);

    // The remainder of the new time by the quantum decides preemption.
    rrs_mod_unit u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (in_accept && is_tick),
        .dividend (tick_inc),
        .divisor  (quantum_reg),
        .done     (mod_done),
        .rem_zero (mod_zero)
    );

    // Blocked list as a chain of cells. During the scan every cell takes its
    // right neighbor; the entry leaving cell 0 is either moved to the ready
    // queue or reinserted just behind the entries that are still waiting,
    // so the survivors end up packed at the front in their old order.
    blk_entry_t cell_q [NUM_PROCS];
    cell_ctrl_t cell_ctrl [NUM_PROCS];
    blk_entry_t ld_entry;
    logic       scan_woke, scan_last;
    logic [CNT_BITS-1:0]  ins_pos;

    assign ld_entry.slot = head_slot;
    assign ld_entry.wake = tick_count_reg + block_length_reg[head_slot];
    assign scan_woke     = (cell_q[0].wake == tick_count_reg);
    assign ins_pos       = bcount_reg - scan_idx_reg - 1'b1 + kept_reg;
    assign scan_last     = (scan_idx_reg == bcount_reg - 1'b1);

    for (genvar i = 0; i < NUM_PROCS; i++) begin : g_cell
        blk_entry_t right_entry;
        if (i == NUM_PROCS - 1) begin : g_end
            assign right_entry = cell_q[i];
        end else begin : g_mid
            assign right_entry = cell_q[i+1];
        end

        assign cell_ctrl[i].ld    = (state_reg == ST_RUN) && blk_now
                                    && (bcount_reg[SLOT_BITS-1:0] == SLOT_BITS'(i));
        assign cell_ctrl[i].ins   = (state_reg == ST_SCAN) && !scan_woke
                                    && (ins_pos[SLOT_BITS-1:0] == SLOT_BITS'(i));
        assign cell_ctrl[i].shift = (state_reg == ST_SCAN);

        rrs_blk_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .ld_data    (ld_entry),
            .ins_data   (cell_q[0]),
            .right_data (right_entry),
            .entry      (cell_q[i])
        );
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = is_tick ? ST_MOD : ST_FIN;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (bcount_reg != '0 || blk_now) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = out_data_reg;
        pready   = 1'b1;
        prdata   = (paddr[2] == REG_QUANTUM) ? {24'd0, quantum_reg} : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_count_reg <= '0;
            quantum_reg    <= QUANTUM_RESET;
            head_reg       <= '0;
            rcount_reg     <= '0;
            bcount_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                status_reg[i] <= PS_ABSENT;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_write && (paddr[2] == REG_QUANTUM)) begin
                quantum_reg <= pwdata[Q_BITS-1:0];
            end

            // A new result replaces the one leaving in the same cycle.
            if ((state_reg == ST_FIN) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        ran_valid_reg <= 1'b0;
                        ran_id_reg    <= '0;
                        event_reg     <= EV_IDLE;
                        woken_reg     <= '0;
                        if (is_tick) begin
                            tick_count_reg <= tick_inc;
                        end else if (load_ok) begin
                            remaining_reg[in_proc_id]    <= in_need;
                            consumed_reg[in_proc_id]     <= in_used;
                            block_point_reg[in_proc_id]  <= in_block_at;
                            block_length_reg[in_proc_id] <= in_len;
                            status_reg[in_proc_id]       <= PS_READY;
                            fifo_reg[tail_pos]           <= in_proc_id;
                            rcount_reg                   <= rcount_reg + 1'b1;
                        end
                    end
                end
                ST_MOD: begin
                end
                ST_RUN: begin
                    scan_idx_reg <= '0;
                    kept_reg     <= '0;
                    if (run_any) begin
                        ran_valid_reg            <= 1'b1;
                        ran_id_reg               <= head_slot;
                        remaining_reg[head_slot] <= rem_dec;
                        consumed_reg[head_slot]  <= cons_inc;
                        if (run_fin) begin
                            head_reg              <= head_reg + 1'b1;
                            rcount_reg            <= rcount_reg - 1'b1;
                            status_reg[head_slot] <= PS_FINISHED;
                            event_reg             <= EV_FINISH;
                        end else if (run_blk) begin
                            head_reg              <= head_reg + 1'b1;
                            rcount_reg            <= rcount_reg - 1'b1;
                            status_reg[head_slot] <= PS_BLOCKED;
                            bcount_reg            <= bcount_reg + 1'b1;
                            event_reg             <= EV_BLOCK;
                        end else if (run_pre) begin
                            // The preempted head is written at the tail, behind the last queued entry.
                            fifo_reg[tail_pos] <= head_slot;
                            head_reg           <= head_reg + 1'b1;
                            event_reg          <= EV_PREEMPT;
                        end else begin
                            event_reg <= EV_CONT;
                        end
                    end
                end
                ST_SCAN: begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (scan_woke) begin
                        fifo_reg[tail_pos]          <= cell_q[0].slot;
                        rcount_reg                  <= rcount_reg + 1'b1;
                        status_reg[cell_q[0].slot]  <= PS_READY;
                        woken_reg[cell_q[0].slot]   <= 1'b1;
                    end else begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                    if (scan_last) begin
                        bcount_reg <= scan_woke ? kept_reg : kept_reg + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        out_data_reg <= {(rcount_reg == '0) && (bcount_reg == '0),
                                         woken_reg, event_reg, ran_id_reg,
                                         ran_valid_reg, tick_count_reg};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The two queues together never hold more entries than slots. During the scan the
    // blocked count is only settled at the last entry, so the check waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN)
        |-> ((5'(rcount_reg) + 5'(bcount_reg)) <= 5'(NUM_PROCS)))
        else $error("ready and blocked queues hold more entries than slots");

    // The scan never runs past the entries that were blocked when it began.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_idx_reg < bcount_reg))
        else $error("blocked-list scan overran its entry count");

    // An accepted request always leaves the idle state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    // A result is produced only from the final step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the final step");

endmodule
